/* sv/hpp_pkg.sv */
package hpp_pkg;

  localparam int PIXEL_BITS    = 12;
  localparam int OUT_FRAC_BITS = 8;

  localparam int COEF_W     = 48;
  localparam int ACC_W      = 64;
  localparam int OUT_W      = 32;
  localparam int NUM_COEF   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int COEF_SEL_W = $clog2(NUM_COEF);

  // quotient holds 32 integer bits plus the fraction
  localparam int QUO_W     = OUT_W + OUT_FRAC_BITS;
  localparam int DIV_STEPS = QUO_W;
  localparam int DZ_SHIFT  = 32 - OUT_FRAC_BITS;

  // multiply, sum, magnitude, divider set-up, divider steps, output
  localparam int NUM_STAGES = 4 + DIV_STEPS + 1;

  localparam logic [ACC_W-1:0] ONE_Q32 = ACC_W'(64'h1_0000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0C0 = 4'd0,
    REG_R0C1 = 4'd1,
    REG_R0C2 = 4'd2,
    REG_R1C0 = 4'd3,
    REG_R1C1 = 4'd4,
    REG_R1C2 = 4'd5,
    REG_R2C0 = 4'd6,
    REG_R2C1 = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic                    denominator_zero;
    logic                    saturated;
  } world_t;

  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [31:0]      num_lo;
    logic             neg;
    logic             over;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]      lane;
    logic [ACC_W-1:0] den;
    logic             dz;
  } div_t;

endpackage

/* sv/homography_point_projection_core.sv */
// homography point projection core
// maps a pixel coordinate pair through a 3x3 homography (bottom-right term
// fixed at 1.0) to ground-plane world coordinates in signed q23.8 mm
//
// channels
//   in_*  : one pixel pair per transfer (in_valid high, in_stall low)
//   out_* : one world point per transfer, with zero-denominator and
//           saturation flags (out_valid high, out_stall low)
//   cfg_* : eight q15.32 coefficients, to be written by the user only
//           while the core is idle, which the core does not enforce;
//           cfg_ready is always high, an index beyond the list is ignored
// one pair is taken every cycle while in_stall is low. the pipeline depth
// is set by the long divider: one quotient bit per stage, 40 bits for 32
// integer plus 8 fraction bits
//
// reset (synchronous, rst_n low) clears every stage valid and loads the
// identity coefficients. when the receiver stalls, the output register
// holds; earlier stages keep filling bubbles, and in_stall rises only when
// every stage holds an item
module homography_point_projection_core
  import hpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pix_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output world_t               out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  logic signed [COEF_W-1:0] coef_r [NUM_COEF];

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   en;

  // stage 0: six products
  logic signed [ACC_W-1:0] prod_r [6];
  // stage 1: the three numerators
  logic [ACC_W-1:0] nx_r, ny_r, nz_r;
  // stage 2: magnitudes and signs
  logic [ACC_W-1:0] mx_r, my_r, md_r;
  logic             sx_r, sy_r, dz_r;
  logic             nz_sign_r;
  // stage 3 onward: divider
  div_t div_r [DIV_STEPS+1];
  world_t out_r;

  assign cfg_ready = 1'b1;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= '0;
      coef_r[COEF_SEL_W'(REG_R0C0)] <= COEF_W'(ONE_Q32);
      coef_r[COEF_SEL_W'(REG_R1C1)] <= COEF_W'(ONE_Q32);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < CFG_IDX_W'(NUM_COEF)) begin
        coef_r[cfg_index[COEF_SEL_W-1:0]] <= cfg_data;
      end
    end
  end

  // stall chain: a stage loads when empty or when its successor moves
  assign en[NUM_STAGES] = !out_stall;
  genvar k;
  generate
    for (k = 0; k < NUM_STAGES; k++) begin : g_en
      assign en[k] = !vld_r[k] || en[k+1];
    end
  endgenerate

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 0: products, coefficient times zero-extended pixel
  logic signed [PIXEL_BITS:0] px_s, py_s;
  assign px_s = $signed({1'b0, in_data.pixel_x});
  assign py_s = $signed({1'b0, in_data.pixel_y});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r[0] <= ACC_W'(coef_r[COEF_SEL_W'(REG_R0C0)] * px_s);
      prod_r[1] <= ACC_W'(coef_r[COEF_SEL_W'(REG_R0C1)] * py_s);
      prod_r[2] <= ACC_W'(coef_r[COEF_SEL_W'(REG_R1C0)] * px_s);
      prod_r[3] <= ACC_W'(coef_r[COEF_SEL_W'(REG_R1C1)] * py_s);
      prod_r[4] <= ACC_W'(coef_r[COEF_SEL_W'(REG_R2C0)] * px_s);
      prod_r[5] <= ACC_W'(coef_r[COEF_SEL_W'(REG_R2C1)] * py_s);
    end
  end

  // stage 1: numerators, wrapping at 64 bits
  always_ff @(posedge clk) begin
    if (en[1]) begin
      nx_r <= prod_r[0] + prod_r[1] + ACC_W'(coef_r[COEF_SEL_W'(REG_R0C2)]);
      ny_r <= prod_r[2] + prod_r[3] + ACC_W'(coef_r[COEF_SEL_W'(REG_R1C2)]);
      nz_r <= prod_r[4] + prod_r[5] + ONE_Q32;
    end
  end

  // stage 2: sign and magnitude
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sx_r <= nx_r[ACC_W-1];
      sy_r <= ny_r[ACC_W-1];
      mx_r <= nx_r[ACC_W-1] ? (~nx_r + 1'b1) : nx_r;
      my_r <= ny_r[ACC_W-1] ? (~ny_r + 1'b1) : ny_r;
      md_r <= nz_r[ACC_W-1] ? (~nz_r + 1'b1) : nz_r;
      dz_r <= (nz_r == '0);
      nz_sign_r <= nz_r[ACC_W-1];
    end
  end

  // stage 3: divider set-up; the integer part overflows when d is nonzero
  // and n>>32 >= d; the upper dividend bits form the first partial remainder
  div_t div_init;
  always_comb begin
    div_init.den = md_r;
    div_init.dz  = dz_r;
    for (int l = 0; l < 2; l++) begin
      logic [ACC_W-1:0] mag;
      logic             sgn;
      mag = (l == 0) ? mx_r : my_r;
      sgn = (l == 0) ? sx_r : sy_r;
      // zero denominator keeps the numerator sign
      div_init.lane[l].neg    = dz_r ? sgn : (sgn ^ nz_sign_r);
      div_init.lane[l].over   = !dz_r && ((mag >> 32) >= md_r);
      div_init.lane[l].rem    = mag >> 32;
      div_init.lane[l].num_lo = mag[31:0];
      div_init.lane[l].quo    = dz_r ? QUO_W'(mag >> DZ_SHIFT) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) div_r[0] <= div_init;
  end

  // stages 4..: one restoring quotient bit per stage
  generate
    for (k = 1; k <= DIV_STEPS; k++) begin : g_div
      div_t step;
      always_comb begin
        step = div_r[k-1];
        for (int l = 0; l < 2; l++) begin
          logic [ACC_W:0] rs;
          logic           ge;
          rs = {div_r[k-1].lane[l].rem, div_r[k-1].lane[l].num_lo[31]};
          ge = rs >= {1'b0, div_r[k-1].den};
          step.lane[l].num_lo = {div_r[k-1].lane[l].num_lo[30:0], 1'b0};
          if (!div_r[k-1].dz) begin
            step.lane[l].rem = ge ? ACC_W'(rs - {1'b0, div_r[k-1].den}) : ACC_W'(rs);
            step.lane[l].quo = {div_r[k-1].lane[l].quo[QUO_W-2:0], ge};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en[3+k]) div_r[k] <= step;
      end
    end
  endgenerate

  // output stage: saturate and apply sign
  world_t res;
  always_comb begin
    logic [QUO_W-1:0] lim [2];
    logic [QUO_W-1:0] val [2];
    logic             sat [2];
    logic [OUT_W-1:0] w   [2];
    for (int l = 0; l < 2; l++) begin
      lim[l] = div_r[DIV_STEPS].lane[l].neg ? QUO_W'(33'h0_8000_0000)
                                            : QUO_W'(33'h0_7FFF_FFFF);
      sat[l] = div_r[DIV_STEPS].lane[l].over ||
               (div_r[DIV_STEPS].lane[l].quo > lim[l]);
      val[l] = sat[l] ? lim[l] : div_r[DIV_STEPS].lane[l].quo;
      w[l]   = div_r[DIV_STEPS].lane[l].neg ? (OUT_W'(0) - val[l][OUT_W-1:0])
                                            : val[l][OUT_W-1:0];
    end
    res.world_x          = $signed(w[0]);
    res.world_y          = $signed(w[1]);
    res.denominator_zero = div_r[DIV_STEPS].dz;
    res.saturated        = sat[0] || sat[1];
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) out_r <= res;
  end

  assign out_valid = vld_r[NUM_STAGES-1];
  assign out_data  = out_r;

  // input stalls only with a full pipeline held by the receiver
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled with room in the pipeline");

  // a saturated result sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.world_x == 32'sh7FFF_FFFF || out_data.world_x == -32'sh8000_0000 ||
      out_data.world_y == 32'sh7FFF_FFFF || out_data.world_y == -32'sh8000_0000)
    else $error("saturation flag without clipped coordinate");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
